// File: rtl/unsigned_to_ascii_any_base_top_assert.svh
// ----------------------------------------------------------------------------
// unsigned_to_ascii_any_base_top_assert.svh
// Assertion macros shared by the radix conversion RTL.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_ASCII_ANY_BASE_TOP_ASSERT_SVH
`define UNSIGNED_TO_ASCII_ANY_BASE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define U2A_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define U2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg
// Types, constants and the digit-to-character map for the radix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u2a_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int VAL_PORT_W      = 32;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
  localparam logic [RADIX_W-1:0] DEFAULT_BASE = 6'd10;
  localparam logic [RADIX_W-1:0] MIN_BASE     = 6'd2;
  localparam logic [RADIX_W-1:0] MAX_BASE     = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 7'h57;  // 'a' - 10
  localparam logic [CHAR_W-1:0] CHAR_ERROR  = 7'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WR,
    ST_RD,
    ST_EMIT
  } state_t;

  // Digit 0..35 to '0'..'9', 'a'..'z'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < 6'd10) begin
      return CHAR_ZERO + d_ext;
    end else begin
      return CHAR_ALPHA + d_ext;
    end
  endfunction

endpackage

// File: rtl/u2a_ram.sv
// ----------------------------------------------------------------------------
// u2a_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/unsigned_to_ascii_any_base_top.sv
// Each digit comes from a restoring division over all VALUE_WIDTH dividend bits and is
//   written to the digit buffer; each character is then read back and emitted in turn.
// The shared 1-bit restoring divide step takes one dividend bit per step; busy stays high until the last character.
// A bad radix gives its single error result the cycle after start, busy stays low.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (rst_n low, synchronous) returns to idle and sets the radix to 10.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// unsigned_to_ascii_any_base_top
// Unsigned integer to ASCII text in a programmable radix, MSD first.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_any_base_top #(
  parameter int VALUE_WIDTH = u2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [u2a_pkg::RADIX_W-1:0]    cfg_wr_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [u2a_pkg::VAL_PORT_W-1:0] in_value,
  output logic                           out_strobe,
  output logic [u2a_pkg::CHAR_W-1:0]     out_character,
  output logic                           out_last,
  output logic                           out_bad_radix
);

  import u2a_pkg::*;

  localparam int CNT_W  = $clog2(VALUE_WIDTH);
  localparam int NDIG_W = $clog2(VALUE_WIDTH + 1);
  localparam int ADDR_W = $clog2(VALUE_WIDTH);

  state_t state_r, state_nxt;

  logic [RADIX_W-1:0]     radix_r;
  logic [RADIX_W-1:0]     base_r, base_nxt;
  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [NDIG_W-1:0]      ndig_r, ndig_nxt;

  logic                   out_strobe_r, out_strobe_nxt;
  logic [CHAR_W-1:0]      out_character_r, out_character_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_bad_radix_r, out_bad_radix_nxt;

  logic [VALUE_WIDTH-1:0] v_in;
  logic [RADIX_W-1:0]     eff_base;
  logic                   bad_base;
  logic                   accept;
  logic [RADIX_W:0]       rem_shift;
  logic [RADIX_W:0]       rem_sub;
  logic                   ge;
  logic [NDIG_W-1:0]      ndig_dec;
  logic                   ram_we;
  logic [RADIX_W-1:0]     ram_rdata;

  generate
    if (VALUE_WIDTH <= VAL_PORT_W) begin : g_trunc
      assign v_in = in_value[VALUE_WIDTH-1:0];
    end else begin : g_ext
      assign v_in = {{(VALUE_WIDTH - VAL_PORT_W){1'b0}}, in_value};
    end
  endgenerate

  assign eff_base = (radix_r == '0) ? DEFAULT_BASE : radix_r;
  assign bad_base = (eff_base < MIN_BASE) || (eff_base > MAX_BASE);
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;

  // One restoring divide step: shift in the next dividend bit, compare, subtract
  assign rem_shift = {rem_r, q_r[VALUE_WIDTH-1]};
  assign rem_sub   = rem_shift - {1'b0, base_r};
  assign ge        = (rem_shift >= {1'b0, base_r});
  assign ndig_dec  = ndig_r - 1'b1;

  // Digits land least significant first, read back from the top down
  u2a_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ndig_r[ADDR_W-1:0]),
    .wdata (rem_r),
    .raddr (ndig_dec[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !bad_base) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        state_nxt = (q_r == '0) ? ST_RD : ST_DIV;
      end
      ST_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        state_nxt = (ndig_r == NDIG_W'(1)) ? ST_IDLE : ST_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    base_nxt          = base_r;
    q_nxt             = q_r;
    rem_nxt           = rem_r;
    bit_cnt_nxt       = bit_cnt_r;
    ndig_nxt          = ndig_r;
    out_strobe_nxt    = 1'b0;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    out_bad_radix_nxt = out_bad_radix_r;
    ram_we            = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          base_nxt    = eff_base;
          q_nxt       = v_in;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          ndig_nxt    = '0;
          if (bad_base) begin
            out_strobe_nxt    = 1'b1;
            out_character_nxt = CHAR_ERROR;
            out_last_nxt      = 1'b1;
            out_bad_radix_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        q_nxt       = {q_r[VALUE_WIDTH-2:0], ge};
        rem_nxt     = ge ? rem_sub[RADIX_W-1:0] : rem_shift[RADIX_W-1:0];
        bit_cnt_nxt = bit_cnt_r + 1'b1;
      end
      ST_WR: begin
        ram_we      = 1'b1;
        ndig_nxt    = ndig_r + 1'b1;
        rem_nxt     = '0;
        bit_cnt_nxt = '0;
      end
      ST_RD: begin
        ndig_nxt = ndig_r;
      end
      ST_EMIT: begin
        out_strobe_nxt    = 1'b1;
        out_character_nxt = digit_char(ram_rdata);
        out_last_nxt      = (ndig_r == NDIG_W'(1));
        out_bad_radix_nxt = 1'b0;
        ndig_nxt          = ndig_dec;
      end
      default: begin
        ndig_nxt = ndig_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      radix_r      <= RADIX_RESET;
      out_strobe_r <= 1'b0;
      bit_cnt_r    <= '0;
      ndig_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      ndig_r       <= ndig_nxt;
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r          <= base_nxt;
    q_r             <= q_nxt;
    rem_r           <= rem_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
    out_bad_radix_r <= out_bad_radix_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;
  assign out_bad_radix = out_bad_radix_r;

  `include "unsigned_to_ascii_any_base_top_assert.svh"

  `U2A_ASSERT_NEXT(a_bad_radix_result, accept && bad_base, out_strobe && out_bad_radix && out_last, "bad radix transfer not flagged")
  `U2A_ASSERT_SAME(a_error_char_zero, out_strobe && out_bad_radix, out_character == CHAR_ERROR && out_last, "error result carries a character")
  `U2A_ASSERT_SAME(a_rem_below_base, state_r == ST_WR, rem_r < base_r, "digit not below base")
  `U2A_ASSERT_SAME(a_emit_has_digit, state_r == ST_EMIT || state_r == ST_RD, ndig_r != '0, "digit buffer empty on readout")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the radix converter: feeds 32-bit values over the
// start/busy command port under several radix settings and checks every
// strobed character, last and bad_radix flag against a built-in predictor.
// ----------------------------------------------------------------------------
module testbench;

  import u2a_pkg::*;

  localparam int IDLE_PCT   = 37;
  localparam int PRINT_CAP  = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bad;
  } char_exp_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0]     cfg_wr_data = '0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [VAL_PORT_W-1:0]  in_value = '0;
  logic                   out_strobe;
  logic [CHAR_W-1:0]      out_character;
  logic                   out_last;
  logic                   out_bad_radix;

  logic [VAL_PORT_W-1:0]  pending_values [$];
  char_exp_t              expected_chars [$];
  logic [RADIX_W-1:0]     radix_shadow = RADIX_RESET;
  logic                   sender_gaps = 1'b1;
  logic                   took;
  char_exp_t              got;
  char_exp_t              want;
  int                     mismatch_count = 0;

  unsigned_to_ascii_any_base_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_character(out_character),
    .out_last     (out_last),
    .out_bad_radix(out_bad_radix)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Expected characters of one conversion, MSD first
  function automatic void queue_digits(input logic [VAL_PORT_W-1:0] val,
                                       input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0]    base;
    logic [VAL_PORT_W-1:0] rest;
    logic [RADIX_W-1:0]    lsd_first [VAL_PORT_W];
    logic [RADIX_W-1:0]    d;
    int                    n;
    char_exp_t             e;
    base = (r == '0) ? DEFAULT_BASE : r;
    if (base < MIN_BASE || base > MAX_BASE) begin
      e.ch   = CHAR_ERROR;
      e.last = 1'b1;
      e.bad  = 1'b1;
      expected_chars.push_back(e);
      return;
    end
    rest = val;
    n = 0;
    do begin
      lsd_first[n] = RADIX_W'(rest % {{(VAL_PORT_W-RADIX_W){1'b0}}, base});
      rest = rest / {{(VAL_PORT_W-RADIX_W){1'b0}}, base};
      n++;
    end while (rest != '0);
    for (int k = n - 1; k >= 0; k--) begin
      d = lsd_first[k];
      e.ch   = (d < 6'd10) ? CHAR_W'(8'h30 + d) : CHAR_W'(8'h61 + d - 6'd10);
      e.last = (k == 0);
      e.bad  = 1'b0;
      expected_chars.push_back(e);
    end
  endfunction

  // Mix of full-range, shortened, small and near-power-of-base values
  function automatic logic [VAL_PORT_W-1:0] pick_value(input logic [RADIX_W-1:0] r);
    logic [63:0] p;
    int          b;
    int          k;
    b = (r < MIN_BASE || r > MAX_BASE) ? 10 : int'(r);
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return $urandom >> $urandom_range(0, 31);
      3: return $urandom_range(0, b * b);
      default: begin
        p = 64'd1;
        k = $urandom_range(1, 32);
        while (k > 0 && p * b <= 64'hFFFF_FFFF) begin
          p = p * b;
          k--;
        end
        return VAL_PORT_W'(p - $urandom_range(0, 1));
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Driver: start held until the transfer, then the next value or a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) queue_digits(in_value, radix_shadow);
      if (!start || took) begin
        if (pending_values.size() != 0 &&
            (!sender_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
          start    <= 1'b1;
          in_value <= pending_values.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is a transfer, no back-pressure possible
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      got = '{out_character, out_last, out_bad_radix};
      if (expected_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char %h last %b bad %b",
                                got.ch, got.last, got.bad));
      end else begin
        want = expected_chars.pop_front();
        if (got.ch !== want.ch)
          flag_mismatch($sformatf("character %h, expected %h", got.ch, want.ch));
        if (got.last !== want.last)
          flag_mismatch($sformatf("last %b, expected %b", got.last, want.last));
        if (got.bad !== want.bad)
          flag_mismatch($sformatf("bad_radix %b, expected %b", got.bad, want.bad));
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_values.size() != 0 || start || expected_chars.size() != 0 || busy);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    radix_shadow = r;
  endtask

  task automatic add_random(input int count);
    repeat (count) pending_values.push_back(pick_value(radix_shadow));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radix: decimal edges
    pending_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999,
                       32'd1000000000, 32'h8000_0000, 32'hFFFF_FFFF};
    add_random(40);

    // zero means decimal
    set_radix(6'd0);
    pending_values = '{32'd0, 32'hFFFF_FFFF};
    add_random(30);

    // binary: longest outputs
    set_radix(6'd2);
    pending_values = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'hAAAA_AAAA, 32'h5555_5555};
    add_random(30);

    // top base, with a full drain halfway through
    set_radix(MAX_BASE);
    pending_values = '{32'd35, 32'd36, 32'hFFFF_FFFF, 32'd0};
    add_random(15);
    wait_drained();
    add_random(15);

    // one long stretch without sender gaps
    set_radix(6'd16);
    sender_gaps = 1'b0;
    add_random(30);
    wait_drained();
    sender_gaps = 1'b1;

    // invalid bases give one error result each
    set_radix(6'd1);
    pending_values = '{32'd0, 32'd5};
    add_random(15);
    set_radix(6'd37);
    add_random(10);
    set_radix(6'd63);
    pending_values = '{32'hFFFF_FFFF};
    add_random(10);

    set_radix(6'd8);
    add_random(30);
    set_radix(6'd3);
    add_random(30);
    set_radix(6'd35);
    add_random(30);
    repeat (4) begin
      set_radix(RADIX_W'($urandom_range(0, 63)));
      add_random(30);
    end
    set_radix(DEFAULT_BASE);
    add_random(30);

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
